// ----- sv/qmtf_pkg.sv -----
// Shared types and constants for the move-to-front queue.
// Depends on nothing; imported by every module of the block.
package qmtf_pkg;

  localparam int DEPTH   = 16;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int COUNT_W = 5;
  localparam int POS_W   = 5;

  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_MOVE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_UNDER  = 2'd1;
  localparam logic [1:0] ST_OVER   = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [1:0]        command;
    logic signed [31:0] value;
    logic [POS_W-1:0]  position;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0]  read_value;
    logic [1:0]          status;
    logic [COUNT_W-1:0]  count;
  } out_word_t;

endpackage

// ----- sv/qmtf_slot.sv -----
// Shared slot adder: head index plus offset, wrapped into the store depth.
// Depends on qmtf_pkg.
module qmtf_slot
  import qmtf_pkg::*;
(
  input  logic [PTR_W-1:0] head,
  input  logic [PTR_W-1:0] offset,
  output logic [PTR_W-1:0] slot
);

  logic [PTR_W:0] sum;

  always_comb begin
    sum = {1'b0, head} + {1'b0, offset};
    if (sum >= (PTR_W+1)'(DEPTH)) begin
      sum = sum - (PTR_W+1)'(DEPTH);
    end
    slot = sum[PTR_W-1:0];
  end

endmodule

// ----- sv/queue_move_nth_to_front_core.sv -----
// Top level: circular word store, command sequencer and output register.
// Depends on qmtf_pkg and qmtf_slot.
// One command at a time, the move loop paced by one store read port.
// Reset clears head index, fill count, sequencer and output valid; store contents stay unset.
module queue_move_nth_to_front_core
  import qmtf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEQ   = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_HEAD  = 3'd4;

  logic [31:0] mem [DEPTH];

  logic [2:0]         state_r, state_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [COUNT_W-1:0] fill_r, fill_nxt;
  logic [PTR_W-1:0]   k_r, k_nxt;
  logic [PTR_W-1:0]   ra_r;
  logic [PTR_W-1:0]   wa_r, wa_nxt;
  logic [31:0]        rdata_r;
  logic [31:0]        picked_r, picked_nxt;
  logic               out_valid_r;
  out_word_t          out_r, out_nxt;
  logic               load;

  logic [PTR_W-1:0] offset;
  logic [PTR_W-1:0] slot;
  logic [PTR_W-1:0] raddr;
  logic             we;
  logic [PTR_W-1:0] waddr;
  logic [31:0]      wdata;
  logic             in_fire;

  qmtf_slot u_slot (
    .head   (head_r),
    .offset (offset),
    .slot   (slot)
  );

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    case (state_r)
      S_IDLE: begin
        if (in_data.command == CMD_ENQ) begin
          offset = fill_r[PTR_W-1:0];
        end else begin
          offset = PTR_W'(in_data.position - POS_W'(1));
        end
      end
      S_DEQ:   offset = PTR_W'(1);
      S_PICK:  offset = k_r - PTR_W'(1);
      S_SHIFT: offset = k_r - PTR_W'(2);
      default: offset = '0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    k_nxt      = k_r;
    wa_nxt     = wa_r;
    picked_nxt = picked_r;
    out_nxt    = out_r;
    load       = 1'b0;
    raddr      = slot;
    we         = 1'b0;
    waddr      = wa_r;
    wdata      = rdata_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_nxt.read_value = '0;
          out_nxt.status     = ST_OK;
          out_nxt.count      = fill_r;
          case (in_data.command)
            CMD_ENQ: begin
              load = 1'b1;
              if (fill_r >= COUNT_W'(DEPTH)) begin
                out_nxt.status = ST_OVER;
              end else begin
                we            = 1'b1;
                waddr         = slot;
                wdata         = in_data.value;
                fill_nxt      = fill_r + COUNT_W'(1);
                out_nxt.count = fill_r + COUNT_W'(1);
              end
            end
            CMD_DEQ: begin
              if (fill_r == '0) begin
                load           = 1'b1;
                out_nxt.status = ST_UNDER;
              end else begin
                raddr     = head_r;
                fill_nxt  = fill_r - COUNT_W'(1);
                state_nxt = S_DEQ;
              end
            end
            CMD_MOVE: begin
              if (fill_r <= COUNT_W'(1) || in_data.position == POS_W'(1)) begin
                load = 1'b1;
              end else if (in_data.position == '0 || in_data.position > fill_r) begin
                load           = 1'b1;
                out_nxt.status = ST_BADPOS;
              end else begin
                k_nxt     = offset;
                state_nxt = S_PICK;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_DEQ: begin
        load               = 1'b1;
        out_nxt.read_value = rdata_r;
        out_nxt.status     = ST_OK;
        out_nxt.count      = fill_r;
        head_nxt           = slot;
        state_nxt          = S_IDLE;
      end
      S_PICK: begin
        picked_nxt = rdata_r;
        wa_nxt     = ra_r;
        state_nxt  = S_SHIFT;
      end
      S_SHIFT: begin
        we     = 1'b1;
        waddr  = wa_r;
        wdata  = rdata_r;
        wa_nxt = ra_r;
        k_nxt  = k_r - PTR_W'(1);
        if (k_r == PTR_W'(1)) begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        we                 = 1'b1;
        waddr              = head_r;
        wdata              = picked_r;
        load               = 1'b1;
        out_nxt.read_value = '0;
        out_nxt.status     = ST_OK;
        out_nxt.count      = fill_r;
        state_nxt          = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    ra_r     <= raddr;
    wa_r     <= wa_nxt;
    k_r      <= k_nxt;
    picked_r <= picked_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= COUNT_W'(DEPTH))
    else $error("fill count exceeds depth");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready)
    else $error("ready while a command is in progress");

  a_late_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEQ || state_r == S_HEAD) |-> !out_valid_r)
    else $error("result would overwrite a pending word");

  a_shift_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> k_r != '0)
    else $error("shift step with zero remaining");

  a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.command == CMD_ENQ && fill_r < COUNT_W'(DEPTH)
    |=> fill_r == $past(fill_r) + COUNT_W'(1))
    else $error("enqueue did not grow the queue");
`endif

endmodule
